// ----- sv/lcfw_pkg.sv -----
// Shared types, constants and gamma table of the LED chain frame writer.
package lcfw_pkg;

    localparam int MAX_LEDS_DEF = 16;
    localparam int LED_W        = 5;
    localparam int CH_W         = 10;
    localparam int CMD_W        = 7;
    localparam int COLOUR_W     = 3 * CH_W;
    localparam int COMMAND_W    = 3 * CMD_W;
    localparam int FUNC_W       = 3;
    localparam int KIND_W       = 2;

    localparam logic [LED_W-1:0] NUM_LEDS_RST = LED_W'(16);

    localparam logic [2:0] ADDR_NUM_LEDS = 3'd0;

    localparam logic [FUNC_W-1:0] FN_RAW_ONE   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_GAMMA_ONE = 3'd1;
    localparam logic [FUNC_W-1:0] FN_CMD_ONE   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_RAW_ALL   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_GAMMA_ALL = 3'd4;
    localparam logic [FUNC_W-1:0] FN_FRAME     = 3'd5;

    localparam logic [KIND_W-1:0] OP_COLOUR_ONE = 2'd0;
    localparam logic [KIND_W-1:0] OP_CMD_ONE    = 2'd1;
    localparam logic [KIND_W-1:0] OP_COLOUR_ALL = 2'd2;
    localparam logic [KIND_W-1:0] OP_FRAME      = 2'd3;

    localparam logic [1:0] MODE_COLOUR  = 2'b00;
    localparam logic [1:0] MODE_COMMAND = 2'b01;

    localparam logic [CH_W-1:0]  NORM_MAX    = CH_W'(255);
    localparam logic [CH_W-1:0]  COMMAND_MAX = CH_W'(127);
    localparam logic [CMD_W-1:0] CMD_FULL    = CMD_W'(127);
    localparam logic [COMMAND_W-1:0] FULL_COMMAND = {CMD_FULL, CMD_FULL, CMD_FULL};

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [3:0]        led_index;
        logic [CH_W-1:0]   red_value;
        logic [CH_W-1:0]   green_value;
        logic [CH_W-1:0]   blue_value;
    } t_in_item;

    typedef struct packed {
        logic        is_latch;
        logic [31:0] packet_word;
        logic        last_of_frame;
    } t_out_item;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [LED_W-1:0]    idx;
        logic [COLOUR_W-1:0] data;
    } t_op;

    typedef struct packed {
        logic             en;
        logic [LED_W-1:0] value;
    } t_cfg_wr;

    localparam logic [CH_W-1:0] GAMMA_ROM [256] = '{
        10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
        10'd0, 10'd0, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1,
        10'd1, 10'd1, 10'd2, 10'd2, 10'd2, 10'd2, 10'd2, 10'd3,
        10'd3, 10'd3, 10'd4, 10'd4, 10'd4, 10'd5, 10'd5, 10'd6,
        10'd6, 10'd6, 10'd7, 10'd7, 10'd8, 10'd8, 10'd9, 10'd10,
        10'd10, 10'd11, 10'd12, 10'd12, 10'd13, 10'd14, 10'd14, 10'd15,
        10'd16, 10'd17, 10'd18, 10'd19, 10'd19, 10'd20, 10'd21, 10'd22,
        10'd23, 10'd24, 10'd26, 10'd27, 10'd28, 10'd29, 10'd30, 10'd31,
        10'd33, 10'd34, 10'd35, 10'd36, 10'd38, 10'd39, 10'd41, 10'd42,
        10'd44, 10'd45, 10'd47, 10'd48, 10'd50, 10'd52, 10'd53, 10'd55,
        10'd57, 10'd58, 10'd60, 10'd62, 10'd64, 10'd66, 10'd68, 10'd70,
        10'd72, 10'd74, 10'd76, 10'd78, 10'd80, 10'd82, 10'd85, 10'd87,
        10'd89, 10'd92, 10'd94, 10'd96, 10'd99, 10'd101, 10'd104, 10'd106,
        10'd109, 10'd112, 10'd114, 10'd117, 10'd120, 10'd123, 10'd125, 10'd128,
        10'd131, 10'd134, 10'd137, 10'd140, 10'd143, 10'd146, 10'd149, 10'd153,
        10'd156, 10'd159, 10'd162, 10'd166, 10'd169, 10'd172, 10'd176, 10'd179,
        10'd183, 10'd187, 10'd190, 10'd194, 10'd198, 10'd201, 10'd205, 10'd209,
        10'd213, 10'd217, 10'd221, 10'd225, 10'd229, 10'd233, 10'd237, 10'd241,
        10'd246, 10'd250, 10'd254, 10'd258, 10'd263, 10'd267, 10'd272, 10'd276,
        10'd281, 10'd286, 10'd290, 10'd295, 10'd300, 10'd305, 10'd310, 10'd314,
        10'd319, 10'd324, 10'd329, 10'd335, 10'd340, 10'd345, 10'd350, 10'd355,
        10'd361, 10'd366, 10'd372, 10'd377, 10'd383, 10'd388, 10'd394, 10'd400,
        10'd405, 10'd411, 10'd417, 10'd423, 10'd429, 10'd435, 10'd441, 10'd447,
        10'd453, 10'd459, 10'd465, 10'd472, 10'd478, 10'd484, 10'd491, 10'd497,
        10'd504, 10'd510, 10'd517, 10'd524, 10'd530, 10'd537, 10'd544, 10'd551,
        10'd558, 10'd565, 10'd572, 10'd579, 10'd586, 10'd593, 10'd601, 10'd608,
        10'd615, 10'd623, 10'd630, 10'd638, 10'd645, 10'd653, 10'd661, 10'd668,
        10'd676, 10'd684, 10'd692, 10'd700, 10'd708, 10'd716, 10'd724, 10'd732,
        10'd740, 10'd749, 10'd757, 10'd765, 10'd774, 10'd782, 10'd791, 10'd800,
        10'd808, 10'd817, 10'd826, 10'd835, 10'd844, 10'd853, 10'd862, 10'd871,
        10'd880, 10'd889, 10'd898, 10'd908, 10'd917, 10'd926, 10'd936, 10'd945,
        10'd955, 10'd965, 10'd974, 10'd984, 10'd994, 10'd1004, 10'd1014, 10'd1023
    };

    function automatic logic [CH_W-1:0] gamma_of(input logic [CH_W-1:0] v);
        logic [7:0] sat;
        sat = (v > NORM_MAX) ? 8'd255 : v[7:0];
        return GAMMA_ROM[sat];
    endfunction

    function automatic logic [CMD_W-1:0] sat_cmd(input logic [CH_W-1:0] v);
        return (v > COMMAND_MAX) ? CMD_FULL : v[CMD_W-1:0];
    endfunction

endpackage

// ----- sv/lcfw_front.sv -----
// Front end: decodes func, saturates gamma and command inputs and forms a queued operation.
module lcfw_front #(
    parameter int MAX_LEDS = lcfw_pkg::MAX_LEDS_DEF
) (
    input  lcfw_pkg::t_in_item i_item,
    output logic               o_keep,
    output lcfw_pkg::t_op      o_op
);
    import lcfw_pkg::*;

    logic [LED_W-1:0] w_led;
    logic             w_in_range;

    assign w_led      = {1'b0, i_item.led_index};
    assign w_in_range = w_led < LED_W'(MAX_LEDS);

    always_comb begin
        o_keep  = 1'b0;
        o_op    = '0;
        o_op.idx = w_led;
        unique case (i_item.func)
            FN_RAW_ONE: begin
                o_keep      = w_in_range;
                o_op.kind   = OP_COLOUR_ONE;
                o_op.data   = {i_item.blue_value, i_item.red_value, i_item.green_value};
            end
            FN_GAMMA_ONE: begin
                o_keep      = w_in_range;
                o_op.kind   = OP_COLOUR_ONE;
                o_op.data   = {gamma_of(i_item.blue_value), gamma_of(i_item.red_value),
                               gamma_of(i_item.green_value)};
            end
            FN_CMD_ONE: begin
                o_keep      = w_in_range;
                o_op.kind   = OP_CMD_ONE;
                o_op.data   = COLOUR_W'({sat_cmd(i_item.blue_value),
                                         sat_cmd(i_item.red_value),
                                         sat_cmd(i_item.green_value)});
            end
            FN_RAW_ALL: begin
                o_keep      = 1'b1;
                o_op.kind   = OP_COLOUR_ALL;
                o_op.data   = {i_item.blue_value, i_item.red_value, i_item.green_value};
            end
            FN_GAMMA_ALL: begin
                o_keep      = 1'b1;
                o_op.kind   = OP_COLOUR_ALL;
                o_op.data   = {gamma_of(i_item.blue_value), gamma_of(i_item.red_value),
                               gamma_of(i_item.green_value)};
            end
            FN_FRAME: begin
                o_keep      = 1'b1;
                o_op.kind   = OP_FRAME;
            end
            default: begin
                o_keep      = 1'b0;
            end
        endcase
    end

endmodule

// ----- sv/lcfw_fifo.sv -----
// Two-entry operation queue between front end and back end.
module lcfw_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lcfw_pkg::t_op i_data,
    input  logic          i_pop,
    output lcfw_pkg::t_op o_data,
    output logic          o_full,
    output logic          o_empty
);
    import lcfw_pkg::*;

    t_op        r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

// ----- sv/lcfw_back.sv -----
// Back end: LED buffers, count register and frame packet sequencer.
module lcfw_back #(
    parameter int MAX_LEDS = lcfw_pkg::MAX_LEDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lcfw_pkg::t_cfg_wr             i_cfg,
    input  lcfw_pkg::t_op                 i_op,
    input  logic                          i_empty,
    output logic                          o_pop,
    output logic [lcfw_pkg::LED_W-1:0]    o_num_leds,
    output logic                          o_valid,
    output lcfw_pkg::t_out_item           o_result
);
    import lcfw_pkg::*;

    localparam int IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_COLOUR  = 3'd1;
    localparam logic [2:0] ST_LATCH_A = 3'd2;
    localparam logic [2:0] ST_CMD     = 3'd3;
    localparam logic [2:0] ST_LATCH_B = 3'd4;

    logic [COLOUR_W-1:0]  r_colour  [MAX_LEDS];
    logic [COMMAND_W-1:0] r_command [MAX_LEDS];
    logic [LED_W-1:0]     r_num_leds;
    logic [2:0]           r_state, n_state;
    logic [IDX_W-1:0]     r_cnt, n_cnt;
    logic                 r_valid, n_valid;
    t_out_item            r_out, n_out;

    logic [LED_W-1:0]     w_n;
    logic [LED_W-1:0]     w_cfg_n;
    logic [COLOUR_W-1:0]  w_colour;
    logic [COMMAND_W-1:0] w_command;
    logic                 w_last;

    assign w_n     = (r_num_leds > LED_W'(MAX_LEDS)) ? LED_W'(MAX_LEDS) : r_num_leds;
    assign w_cfg_n = (i_cfg.value > LED_W'(MAX_LEDS)) ? LED_W'(MAX_LEDS) : i_cfg.value;
    assign o_pop   = (r_state == ST_IDLE) && !i_empty;
    assign w_colour  = r_colour[r_cnt];
    assign w_command = r_command[r_cnt];
    assign w_last    = LED_W'(r_cnt) == (w_n - LED_W'(1));

    assign o_num_leds = r_num_leds;
    assign o_valid    = r_valid;
    assign o_result   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_leds <= NUM_LEDS_RST;
            for (int i = 0; i < MAX_LEDS; i++) begin
                r_colour[i]  <= '0;
                r_command[i] <= FULL_COMMAND;
            end
        end else begin
            if (i_cfg.en) begin
                r_num_leds <= i_cfg.value;
                for (int i = 0; i < MAX_LEDS; i++) begin
                    if (LED_W'(i) < w_cfg_n) begin
                        r_command[i] <= FULL_COMMAND;
                    end
                end
            end
            if (o_pop) begin
                unique case (i_op.kind)
                    OP_COLOUR_ONE: r_colour[i_op.idx[IDX_W-1:0]] <= i_op.data;
                    OP_CMD_ONE:    r_command[i_op.idx[IDX_W-1:0]] <= i_op.data[COMMAND_W-1:0];
                    OP_COLOUR_ALL: begin
                        for (int i = 0; i < MAX_LEDS; i++) begin
                            if (LED_W'(i) < w_n) begin
                                r_colour[i] <= i_op.data;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_valid = 1'b0;
        n_out   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (o_pop && i_op.kind == OP_FRAME) begin
                    n_cnt   = '0;
                    n_state = (w_n == '0) ? ST_LATCH_A : ST_COLOUR;
                end
            end
            ST_COLOUR: begin
                n_valid           = 1'b1;
                n_out.packet_word = {MODE_COLOUR, w_colour};
                if (w_last) begin
                    n_cnt   = '0;
                    n_state = ST_LATCH_A;
                end else begin
                    n_cnt = r_cnt + IDX_W'(1);
                end
            end
            ST_LATCH_A: begin
                n_valid        = 1'b1;
                n_out.is_latch = 1'b1;
                n_cnt          = '0;
                n_state        = (w_n == '0) ? ST_LATCH_B : ST_CMD;
            end
            ST_CMD: begin
                n_valid           = 1'b1;
                n_out.packet_word = {MODE_COMMAND,
                                     3'b000, w_command[20:14],
                                     3'b000, w_command[13:7],
                                     3'b000, w_command[6:0]};
                if (w_last) begin
                    n_cnt   = '0;
                    n_state = ST_LATCH_B;
                end else begin
                    n_cnt = r_cnt + IDX_W'(1);
                end
            end
            ST_LATCH_B: begin
                n_valid             = 1'b1;
                n_out.is_latch      = 1'b1;
                n_out.last_of_frame = 1'b1;
                n_state             = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

// ----- sv/rgb_led_chain_frame_writer.sv -----
// Top level of the RGB LED chain frame writer.
// Buffer writes (single or all LEDs) are taken into a two-entry queue; while the back
// end is idle it removes one per cycle and applies it at the edge that removes it, so
// back-to-back buffer writes run at one per cycle. A frame write occupies the back end
// from the cycle that removes it until its final latch; with n = min(number_of_leds,
// MAX_LEDS) it makes 2*n+2 transfers on o_valid, one per cycle (n colour packets, a
// latch, n command packets, a final latch marked last_of_frame). busy rises only while
// the queue holds two operations. The receiver cannot stall: every o_valid cycle is a
// transfer.
module rgb_led_chain_frame_writer #(
    parameter int MAX_LEDS = lcfw_pkg::MAX_LEDS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  lcfw_pkg::t_in_item  i_item,
    output logic                o_valid,
    output lcfw_pkg::t_out_item o_result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import lcfw_pkg::*;

    logic             w_keep;
    t_op              w_front_op;
    t_op              w_queue_op;
    logic             w_full;
    logic             w_empty;
    logic             w_pop;
    logic             w_push;
    t_cfg_wr          w_cfg;
    logic [LED_W-1:0] w_num_leds;

    assign pready = 1'b1;
    assign busy   = w_full;
    assign w_push = start && !w_full && w_keep;

    assign w_cfg.en    = psel && penable && pwrite && pready &&
                         (paddr[2] == ADDR_NUM_LEDS[2]);
    assign w_cfg.value = pwdata[LED_W-1:0];
    assign prdata      = (paddr[2] == ADDR_NUM_LEDS[2]) ?
                         {{(32 - LED_W){1'b0}}, w_num_leds} : '0;

    lcfw_front #(
        .MAX_LEDS (MAX_LEDS)
    ) u_front (
        .i_item (i_item),
        .o_keep (w_keep),
        .o_op   (w_front_op)
    );

    lcfw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_op),
        .i_pop   (w_pop),
        .o_data  (w_queue_op),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    lcfw_back #(
        .MAX_LEDS (MAX_LEDS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_op       (w_queue_op),
        .i_empty    (w_empty),
        .o_pop      (w_pop),
        .o_num_leds (w_num_leds),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

endmodule

// ----- dv/rgb_led_chain_frame_writer_test.sv -----
// Self-checking testbench of the RGB LED chain frame writer.
`timescale 1ns / 100ps

module rgb_led_chain_frame_writer_test;
    import lcfw_pkg::*;

    localparam logic [FUNC_W-1:0] FN_SPARE_LO  = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_HI  = 3'd7;
    localparam int                NUM_LEDS     = MAX_LEDS_DEF;
    localparam int                DRAIN_CYCLES = 12;
    localparam int                QUIET_LIMIT  = 1000;
    localparam int                ITEMS_PER_PHASE = 15;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_in_item    i_item = '0;
    logic        o_valid;
    t_out_item   o_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    t_in_item  pending_items[$];
    t_out_item expected_packets[$];

    logic [COLOUR_W-1:0]  colour_mem  [NUM_LEDS];
    logic [COMMAND_W-1:0] command_mem [NUM_LEDS];
    logic [LED_W-1:0]     led_count_reg;

    int idle_pct = 0;
    int fail_count = 0;
    int items_in = 0;
    int packets_checked = 0;
    int settings_done = 0;
    int quiet_cycles = 0;

    rgb_led_chain_frame_writer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_result(o_result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [CH_W-1:0] clip(input logic [CH_W-1:0] v,
                                             input logic [CH_W-1:0] top);
        return (v > top) ? top : v;
    endfunction

    function automatic int active_leds();
        return (led_count_reg > NUM_LEDS) ? NUM_LEDS : int'(led_count_reg);
    endfunction

    function automatic logic [COLOUR_W-1:0] raw_colour(input t_in_item it);
        return {clip(it.blue_value, 10'd1023), clip(it.red_value, 10'd1023),
                clip(it.green_value, 10'd1023)};
    endfunction

    function automatic logic [COLOUR_W-1:0] gamma_colour(input t_in_item it);
        return {GAMMA_ROM[8'(clip(it.blue_value, NORM_MAX))],
                GAMMA_ROM[8'(clip(it.red_value, NORM_MAX))],
                GAMMA_ROM[8'(clip(it.green_value, NORM_MAX))]};
    endfunction

    function automatic t_out_item packet(input logic latch, input logic [31:0] word,
                                         input logic last);
        t_out_item p;
        p.is_latch = latch;
        p.packet_word = word;
        p.last_of_frame = last;
        return p;
    endfunction

    function automatic void apply_item(input t_in_item it);
        int n;
        logic [COMMAND_W-1:0] c;
        n = active_leds();
        case (it.func)
            FN_RAW_ONE:   colour_mem[it.led_index] = raw_colour(it);
            FN_GAMMA_ONE: colour_mem[it.led_index] = gamma_colour(it);
            FN_CMD_ONE:   command_mem[it.led_index] = {CMD_W'(clip(it.blue_value, COMMAND_MAX)),
                                                       CMD_W'(clip(it.red_value, COMMAND_MAX)),
                                                       CMD_W'(clip(it.green_value, COMMAND_MAX))};
            FN_RAW_ALL:   for (int i = 0; i < n; i++) colour_mem[i] = raw_colour(it);
            FN_GAMMA_ALL: for (int i = 0; i < n; i++) colour_mem[i] = gamma_colour(it);
            FN_FRAME: begin
                for (int i = 0; i < n; i++)
                    expected_packets.push_back(packet(1'b0, {MODE_COLOUR, colour_mem[i]}, 1'b0));
                expected_packets.push_back(packet(1'b1, 32'd0, 1'b0));
                for (int i = 0; i < n; i++) begin
                    c = command_mem[i];
                    expected_packets.push_back(packet(1'b0,
                        {MODE_COMMAND, 3'd0, c[20:14], 3'd0, c[13:7], 3'd0, c[6:0]}, 1'b0));
                end
                expected_packets.push_back(packet(1'b1, 32'd0, 1'b1));
            end
            default: ;
        endcase
    endfunction

    function automatic t_in_item make_item(input logic [FUNC_W-1:0] f, input logic [3:0] idx,
                                           input int r, input int g, input int b);
        t_in_item it;
        it.func = f;
        it.led_index = idx;
        it.red_value = CH_W'(r);
        it.green_value = CH_W'(g);
        it.blue_value = CH_W'(b);
        return it;
    endfunction

    function automatic logic [CH_W-1:0] pick_level();
        case ($urandom_range(7))
            0: return 10'd0;
            1: return 10'd1023;
            2: return CH_W'($urandom_range(135, 120));
            3: return CH_W'($urandom_range(260, 250));
            default: return CH_W'($urandom_range(1023));
        endcase
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        int r;
        r = $urandom_range(99);
        if (r < 15)      it.func = FN_FRAME;
        else if (r < 31) it.func = FN_RAW_ONE;
        else if (r < 47) it.func = FN_GAMMA_ONE;
        else if (r < 63) it.func = FN_CMD_ONE;
        else if (r < 74) it.func = FN_RAW_ALL;
        else if (r < 85) it.func = FN_GAMMA_ALL;
        else if (r < 92) it.func = FN_SPARE_LO;
        else             it.func = FN_SPARE_HI;
        it.led_index = 4'($urandom_range(15));
        it.red_value = pick_level();
        it.green_value = pick_level();
        it.blue_value = pick_level();
        return it;
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || start || expected_packets.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_led_count(input logic [LED_W-1:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_NUM_LEDS;
        pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        led_count_reg = value;
        for (int i = 0; i < active_leds(); i++) command_mem[i] = FULL_COMMAND;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== 32'(value)) begin
            $error("number_of_leds readback: expected %0d, actual %0d", value, prdata);
            fail_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        settings_done++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
                start <= 1'b1;
                i_item <= pending_items.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (expected_packets.size() == 0) begin
                    $error("unexpected result transfer: is_latch %0d packet_word %h",
                           o_result.is_latch, o_result.packet_word);
                    fail_count++;
                end else begin
                    want = expected_packets.pop_front();
                    packets_checked++;
                    if (o_result.is_latch !== want.is_latch) begin
                        $error("is_latch: expected %0d, actual %0d", want.is_latch,
                               o_result.is_latch);
                        fail_count++;
                    end
                    if (o_result.packet_word !== want.packet_word) begin
                        $error("packet_word: expected %h, actual %h", want.packet_word,
                               o_result.packet_word);
                        fail_count++;
                    end
                    if (o_result.last_of_frame !== want.last_of_frame) begin
                        $error("last_of_frame: expected %0d, actual %0d", want.last_of_frame,
                               o_result.last_of_frame);
                        fail_count++;
                    end
                end
            end
            if (start && !busy) begin
                apply_item(i_item);
                items_in++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [LED_W-1:0] counts[6];
        int made;
        t_in_item it;

        counts = '{5'd0, 5'd31, 5'd1, 5'd5, 5'd17, 5'd16};
        for (int i = 0; i < NUM_LEDS; i++) begin
            colour_mem[i] = '0;
            command_mem[i] = FULL_COMMAND;
        end
        led_count_reg = NUM_LEDS_RST;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        pending_items.push_back(make_item(FN_FRAME, 4'd0, 0, 0, 0));
        pending_items.push_back(make_item(FN_RAW_ONE, 4'd0, 1023, 1023, 1023));
        pending_items.push_back(make_item(FN_RAW_ONE, 4'd15, 0, 1023, 1));
        pending_items.push_back(make_item(FN_GAMMA_ONE, 4'd1, 255, 256, 1023));
        pending_items.push_back(make_item(FN_GAMMA_ONE, 4'd2, 0, 254, 128));
        pending_items.push_back(make_item(FN_CMD_ONE, 4'd0, 127, 128, 1023));
        pending_items.push_back(make_item(FN_CMD_ONE, 4'd15, 0, 1, 126));
        pending_items.push_back(make_item(FN_FRAME, 4'd15, 1023, 1023, 1023));
        pending_items.push_back(make_item(FN_RAW_ALL, 4'd7, 1023, 512, 0));
        pending_items.push_back(make_item(FN_FRAME, 4'd0, 0, 0, 0));
        pending_items.push_back(make_item(FN_GAMMA_ALL, 4'd9, 0, 255, 1023));
        pending_items.push_back(make_item(FN_SPARE_LO, 4'd3, 1023, 1023, 1023));
        pending_items.push_back(make_item(FN_SPARE_HI, 4'd12, 1023, 1023, 1023));
        pending_items.push_back(make_item(FN_FRAME, 4'd0, 0, 0, 0));
        wait_drained();

        for (int p = 0; p < 6; p++) begin
            set_led_count(counts[p]);
            case (p % 4)
                1:       idle_pct = 59;
                3:       idle_pct = 34;
                default: idle_pct = 0;
            endcase
            made = 0;
            while (made < ITEMS_PER_PHASE) begin
                it = random_item();
                pending_items.push_back(it);
                if (it.func != FN_SPARE_LO && it.func != FN_SPARE_HI) made++;
            end
            pending_items.push_back(make_item(FN_FRAME, 4'd0, 0, 0, 0));
            wait_drained();
        end

        $display("Covered %0d input transfers and %0d checked packets over %0d count settings.",
                 items_in, packets_checked, settings_done);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
